@@ rtl/qvao_pkg.sv @@
// shared constants and half-plane class codes for the quad angular sorter
package qvao_pkg;

  localparam int QVAO_COORD_BITS = 16;
  localparam int QVAO_NUM_PTS    = 4;

  localparam logic [1:0] CLS_LOWER    = 2'd0;
  localparam logic [1:0] CLS_AXIS_POS = 2'd1;
  localparam logic [1:0] CLS_UPPER    = 2'd2;
  localparam logic [1:0] CLS_AXIS_NEG = 2'd3;

  typedef struct packed {
    logic a_b;
    logic b_a;
  } prec_t;

endpackage

@@ rtl/qvao_front.sv @@
// centroid and per-point offset and class stages
module qvao_front import qvao_pkg::*; #(
  parameter int COORD_BITS = QVAO_COORD_BITS
) (
  input  logic                                         clk,
  input  logic                                         en,
  input  logic [QVAO_NUM_PTS-1:0][COORD_BITS-1:0]      p_x,
  input  logic [QVAO_NUM_PTS-1:0][COORD_BITS-1:0]      p_y,
  output logic [QVAO_NUM_PTS-1:0][COORD_BITS-1:0]      pt_x,
  output logic [QVAO_NUM_PTS-1:0][COORD_BITS-1:0]      pt_y,
  output logic signed [QVAO_NUM_PTS-1:0][COORD_BITS:0] dx,
  output logic signed [QVAO_NUM_PTS-1:0][COORD_BITS:0] dy,
  output logic [QVAO_NUM_PTS-1:0][1:0]                 cls
);

  localparam int SW = COORD_BITS + 2;

  logic [QVAO_NUM_PTS-1:0][COORD_BITS-1:0] s1_x_r, s1_y_r;
  logic [COORD_BITS-1:0]                   cx_r, cy_r;
  logic [SW-1:0]                           sum_x, sum_y;
  logic [QVAO_NUM_PTS-1:0][COORD_BITS-1:0] s2_x_r, s2_y_r;
  logic signed [QVAO_NUM_PTS-1:0][COORD_BITS:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic [QVAO_NUM_PTS-1:0][1:0]            cls_r, cls_nxt;

  // rounded mean per axis
  always_comb begin
    sum_x = SW'(2);
    sum_y = SW'(2);
    for (int i = 0; i < QVAO_NUM_PTS; i++) begin
      sum_x = sum_x + SW'(p_x[i]);
      sum_y = sum_y + SW'(p_y[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r <= p_x;
      s1_y_r <= p_y;
      cx_r   <= sum_x[SW-1:2];
      cy_r   <= sum_y[SW-1:2];
    end
  end

  always_comb begin
    for (int i = 0; i < QVAO_NUM_PTS; i++) begin
      dx_nxt[i] = {1'b0, s1_x_r[i]} - {1'b0, cx_r};
      dy_nxt[i] = {1'b0, s1_y_r[i]} - {1'b0, cy_r};
      if (dy_nxt[i][COORD_BITS]) begin
        cls_nxt[i] = CLS_LOWER;
      end else if (dy_nxt[i] == '0) begin
        cls_nxt[i] = dx_nxt[i][COORD_BITS] ? CLS_AXIS_NEG : CLS_AXIS_POS;
      end else begin
        cls_nxt[i] = CLS_UPPER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x_r <= s1_x_r;
      s2_y_r <= s1_y_r;
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      cls_r  <= cls_nxt;
    end
  end

  assign pt_x = s2_x_r;
  assign pt_y = s2_y_r;
  assign dx   = dx_r;
  assign dy   = dy_r;
  assign cls  = cls_r;

endmodule

@@ rtl/qvao_lane.sv @@
// pairwise angle comparator lane: cross products then ordering decision
module qvao_lane import qvao_pkg::*; #(
  parameter int COORD_BITS = QVAO_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS:0]   a_dx,
  input  logic signed [COORD_BITS:0]   a_dy,
  input  logic [1:0]                   a_cls,
  input  logic signed [COORD_BITS:0]   b_dx,
  input  logic signed [COORD_BITS:0]   b_dy,
  input  logic [1:0]                   b_cls,
  output prec_t                        prec
);

  localparam int PW = 2 * COORD_BITS + 2;

  logic signed [PW-1:0] prod_ab_r, prod_ba_r;
  logic [1:0]           a_cls_r, b_cls_r;
  prec_t                prec_r, prec_nxt;
  logic                 in_half;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_ab_r <= PW'(a_dx) * PW'(b_dy);
      prod_ba_r <= PW'(a_dy) * PW'(b_dx);
      a_cls_r   <= a_cls;
      b_cls_r   <= b_cls;
    end
  end

  always_comb begin
    in_half = (a_cls_r == CLS_LOWER) || (a_cls_r == CLS_UPPER);
    if (a_cls_r != b_cls_r) begin
      prec_nxt.a_b = a_cls_r < b_cls_r;
      prec_nxt.b_a = b_cls_r < a_cls_r;
    end else begin
      prec_nxt.a_b = in_half && (prod_ab_r > prod_ba_r);
      prec_nxt.b_a = in_half && (prod_ba_r > prod_ab_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prec_r <= prec_nxt;
    end
  end

  assign prec = prec_r;

endmodule

@@ rtl/qvao_merge.sv @@
// merges lane decisions into stable ranks and places the points in order
module qvao_merge import qvao_pkg::*; #(
  parameter int COORD_BITS = QVAO_COORD_BITS
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [QVAO_NUM_PTS-1:0][QVAO_NUM_PTS-1:0] prec_m,
  input  logic [QVAO_NUM_PTS-1:0][COORD_BITS-1:0] pt_x,
  input  logic [QVAO_NUM_PTS-1:0][COORD_BITS-1:0] pt_y,
  output logic [QVAO_NUM_PTS-1:0][COORD_BITS-1:0] q_x,
  output logic [QVAO_NUM_PTS-1:0][COORD_BITS-1:0] q_y
);

  localparam int RW = $clog2(QVAO_NUM_PTS);

  logic [QVAO_NUM_PTS-1:0][RW-1:0]         rank;
  logic [QVAO_NUM_PTS-1:0][COORD_BITS-1:0] q_x_r, q_y_r, q_x_nxt, q_y_nxt;

  // ties fall back to input order
  always_comb begin
    for (int i = 0; i < QVAO_NUM_PTS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < QVAO_NUM_PTS; j++) begin
        if (j != i) begin
          if (prec_m[j][i] || ((j < i) && !prec_m[i][j])) begin
            rank[i] = rank[i] + RW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    for (int s = 0; s < QVAO_NUM_PTS; s++) begin
      q_x_nxt[s] = '0;
      q_y_nxt[s] = '0;
      for (int i = 0; i < QVAO_NUM_PTS; i++) begin
        if (rank[i] == RW'(s)) begin
          q_x_nxt[s] = q_x_nxt[s] | pt_x[i];
          q_y_nxt[s] = q_y_nxt[s] | pt_y[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_x_r <= q_x_nxt;
      q_y_r <= q_y_nxt;
    end
  end

  assign q_x = q_x_r;
  assign q_y = q_y_r;

endmodule

@@ rtl/quad_vertex_angular_order.sv @@
// top level of the quad angular sorter
//
// sorts the four corners of a quad by angle about their rounded centroid
// input channel: in_valid, in_stall and the four points in_p0..in_p3
// output channel: out_valid, out_stall and the ordered points out_q0..out_q3
// a request is taken at a clock edge with valid high and stall low
// throughput: one request per cycle unless a result waits under out_stall,
//   set by a five stage pipeline with one comparator lane per point pair
//   (six lanes, two multipliers each)
// the pipeline moves as a whole; while a result waits under out_stall every
//   stage holds and in_stall is raised, and it drops in the cycle the result
//   is taken so the next request enters alongside
// ties in angle keep the input order of the points
// reset (rst_n low, synchronous) empties the pipeline; out_valid goes low
//   and nothing in flight is delivered
module quad_vertex_angular_order import qvao_pkg::*; #(
  parameter int COORD_BITS = QVAO_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_p0_x,
  input  logic [COORD_BITS-1:0] in_p0_y,
  input  logic [COORD_BITS-1:0] in_p1_x,
  input  logic [COORD_BITS-1:0] in_p1_y,
  input  logic [COORD_BITS-1:0] in_p2_x,
  input  logic [COORD_BITS-1:0] in_p2_y,
  input  logic [COORD_BITS-1:0] in_p3_x,
  input  logic [COORD_BITS-1:0] in_p3_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_q0_x,
  output logic [COORD_BITS-1:0] out_q0_y,
  output logic [COORD_BITS-1:0] out_q1_x,
  output logic [COORD_BITS-1:0] out_q1_y,
  output logic [COORD_BITS-1:0] out_q2_x,
  output logic [COORD_BITS-1:0] out_q2_y,
  output logic [COORD_BITS-1:0] out_q3_x,
  output logic [COORD_BITS-1:0] out_q3_y
);

  localparam int NSTG = 5;

  logic                                    en;
  logic [NSTG-1:0]                         vld_r, vld_nxt;
  logic [QVAO_NUM_PTS-1:0][COORD_BITS-1:0] p_x, p_y, s2_x, s2_y;
  logic [QVAO_NUM_PTS-1:0][COORD_BITS-1:0] s3_x_r, s3_y_r, s4_x_r, s4_y_r;
  logic signed [QVAO_NUM_PTS-1:0][COORD_BITS:0] dx, dy;
  logic [QVAO_NUM_PTS-1:0][1:0]            cls;
  logic [QVAO_NUM_PTS-1:0][QVAO_NUM_PTS-1:0] prec_m;
  logic [QVAO_NUM_PTS-1:0][COORD_BITS-1:0] q_x, q_y;

  assign en       = !(vld_r[NSTG-1] && out_stall);
  assign in_stall = !en;

  assign p_x = {in_p3_x, in_p2_x, in_p1_x, in_p0_x};
  assign p_y = {in_p3_y, in_p2_y, in_p1_y, in_p0_y};

  assign vld_nxt = {vld_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  qvao_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk  (clk),
    .en   (en),
    .p_x  (p_x),
    .p_y  (p_y),
    .pt_x (s2_x),
    .pt_y (s2_y),
    .dx   (dx),
    .dy   (dy),
    .cls  (cls)
  );

  // points ride alongside the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      s3_x_r <= s2_x;
      s3_y_r <= s2_y;
      s4_x_r <= s3_x_r;
      s4_y_r <= s3_y_r;
    end
  end

  for (genvar i = 0; i < QVAO_NUM_PTS; i++) begin : g_row
    assign prec_m[i][i] = 1'b0;
    for (genvar j = i + 1; j < QVAO_NUM_PTS; j++) begin : g_pair
      prec_t prec;
      qvao_lane #(.COORD_BITS(COORD_BITS)) u_lane (
        .clk   (clk),
        .en    (en),
        .a_dx  (dx[i]),
        .a_dy  (dy[i]),
        .a_cls (cls[i]),
        .b_dx  (dx[j]),
        .b_dy  (dy[j]),
        .b_cls (cls[j]),
        .prec  (prec)
      );
      assign prec_m[i][j] = prec.a_b;
      assign prec_m[j][i] = prec.b_a;
    end
  end

  qvao_merge #(.COORD_BITS(COORD_BITS)) u_merge (
    .clk    (clk),
    .en     (en),
    .prec_m (prec_m),
    .pt_x   (s4_x_r),
    .pt_y   (s4_y_r),
    .q_x    (q_x),
    .q_y    (q_y)
  );

  assign out_valid = vld_r[NSTG-1];
  assign out_q0_x  = q_x[0];
  assign out_q0_y  = q_y[0];
  assign out_q1_x  = q_x[1];
  assign out_q1_y  = q_y[1];
  assign out_q2_x  = q_x[2];
  assign out_q2_y  = q_y[2];
  assign out_q3_x  = q_x[3];
  assign out_q3_y  = q_y[3];

endmodule

@@ rtl/qvao_chk.sv @@
// port-level checker for the quad angular sorter, bound to the top level
module qvao_chk import qvao_pkg::*; #(
  parameter int COORD_BITS = QVAO_COORD_BITS
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] out_q0_x,
  input logic [COORD_BITS-1:0] out_q0_y,
  input logic [COORD_BITS-1:0] out_q1_x,
  input logic [COORD_BITS-1:0] out_q1_y,
  input logic [COORD_BITS-1:0] out_q2_x,
  input logic [COORD_BITS-1:0] out_q2_y,
  input logic [COORD_BITS-1:0] out_q3_x,
  input logic [COORD_BITS-1:0] out_q3_y
);

  // stalled result keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped under stall");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_q0_x) && $stable(out_q0_y) &&
      $stable(out_q1_x) && $stable(out_q1_y) && $stable(out_q2_x) &&
      $stable(out_q2_y) && $stable(out_q3_x) && $stable(out_q3_y))
    else $error("result changed under stall");

  // input only held back by a blocked result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // an accepted request shows up on out_valid when nothing stalls
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_valid && !in_stall && rst_n, 4) && $past(!out_stall && rst_n, 3) &&
      $past(!out_stall && rst_n, 2) && $past(!out_stall && rst_n, 1) && !out_stall
      |=> out_valid)
    else $error("result missing after pipeline latency");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind quad_vertex_angular_order qvao_chk #(.COORD_BITS(COORD_BITS)) u_qvao_chk (.*);
